// ----- hdl/bounded_byte_fifo_stream_unit_macros.svh -----
// Assertion macros used by the checker file of the byte FIFO stream unit.
`ifndef BOUNDED_BYTE_FIFO_STREAM_UNIT_MACROS_SVH
`define BOUNDED_BYTE_FIFO_STREAM_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBFS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("bbfs assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BBFS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("bbfs assertion failed");

`endif

// ----- hdl/bbfs_pkg.sv -----
// Types and constants shared by the byte FIFO stream unit.
package bbfs_pkg;

	localparam int DEPTH_DEF     = 1024;
	localparam int MAX_BURST_DEF = 64;
	localparam int CAP_W         = 11;
	localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

	typedef enum logic [2:0] {
		CMD_WRITE = 3'd0,
		CMD_READ  = 3'd1,
		CMD_PEEK  = 3'd2,
		CMD_POP   = 3'd3,
		CMD_END   = 3'd4
	} cmd_t;

	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_BURST = 1'b1
	} state_t;

endpackage

// ----- hdl/bounded_byte_fifo_stream_unit.sv -----
// Top level of the bounded byte FIFO stream unit.
//
// Command channel: an item (cmd, data_in, count) is taken at a clock edge with
// start high and busy low. Result channel: each result sits on the result
// ports for one cycle with strobe high; the receiver cannot stall it.
// Configuration: cfg_we/cfg_wdata write the capacity register (reset 1024),
// to be written only while the unit is quiet.
// Write, pop, end input, failed or empty read/peek: one result, shown in the
// cycle after the accepting edge; such items can follow each other every
// cycle. Read and peek of n bytes: the bytes come from the byte store's single
// read port, one per cycle, the first once the burst state has issued its
// read and the store has registered the byte; busy stays high through the
// burst, and the next item can be taken at the edge that ends the last byte.
// Status on each result is the state after the whole item was applied.
// A store write and a later read of the same entry never overlap: a burst
// starts reading only in the cycle after its own accept.
// Reset clears pointers, counts and flags and sets the capacity to 1024; the
// byte store is not cleared, as only written entries are ever read.
module bounded_byte_fifo_stream_unit import bbfs_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int MAX_BURST = MAX_BURST_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [2:0]       cmd,
	input  logic [7:0]       data_in,
	input  logic [6:0]       count,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	output logic             strobe,
	output logic [7:0]       data_out,
	output logic             last,
	output logic             accepted,
	output logic             error_flag,
	output logic [10:0]      occupancy,
	output logic [10:0]      space_left,
	output logic [31:0]      total_written,
	output logic [31:0]      total_read,
	output logic             stream_ended,
	output logic             at_eof
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int BW = $clog2(MAX_BURST + 1);
	localparam int XW = (CW > 7) ? CW : 7;
	localparam int EW = (CW > CAP_W) ? CW : CAP_W;

	state_t           state_q, state_d;
	logic [PW-1:0]    head_q, head_d;
	logic [PW-1:0]    tail_q, tail_d;
	logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
	logic [CW-1:0]    fill_q, fill_d;
	logic [31:0]      wr_total_q, wr_total_d;
	logic             ended_q, ended_d;
	logic             err_q, err_d;
	logic [CAP_W-1:0] cap_q;
	logic [BW-1:0]    rem_q, rem_d;
	logic             burst_acc_q, burst_acc_d;
	logic             single_vld_q, single_vld_d;
	logic             single_acc_q, single_acc_d;
	logic             rd_vld_s1, rd_last_s1, rd_acc_s1;

	logic             take;
	logic [6:0]       cnt_c;
	logic             over;
	logic [BW-1:0]    peek_n;
	logic [PW:0]      head_sum;
	logic [PW-1:0]    head_adv;
	logic [EW-1:0]    eff_cap;
	logic [EW-1:0]    space;
	logic             room;
	logic             mem_we;
	logic             mem_re;
	logic [7:0]       mem_rdata;

	assign take  = start && !busy;
	assign busy  = (state_q == ST_BURST);
	assign cnt_c = (count > 7'(MAX_BURST)) ? 7'(MAX_BURST) : count;
	assign over  = XW'(cnt_c) > XW'(fill_q);
	assign peek_n = over ? BW'(fill_q) : BW'(cnt_c);

	// advance head by the count, wrapping once at the store depth
	assign head_sum = (PW + 1)'(head_q) + (PW + 1)'(cnt_c);
	assign head_adv = (head_sum >= (PW + 1)'(DEPTH)) ? PW'(head_sum - (PW + 1)'(DEPTH))
	                                                  : PW'(head_sum);

	// effective capacity and free room
	assign eff_cap = (EW'(cap_q) > EW'(DEPTH)) ? EW'(DEPTH) : EW'(cap_q);
	assign space   = (eff_cap > EW'(fill_q)) ? eff_cap - EW'(fill_q) : '0;
	assign room    = !ended_q && (EW'(fill_q) < eff_cap);

	// next state and command decode
	always_comb begin
		state_d      = state_q;
		head_d       = head_q;
		tail_d       = tail_q;
		rd_ptr_d     = rd_ptr_q;
		fill_d       = fill_q;
		wr_total_d   = wr_total_q;
		ended_d      = ended_q;
		err_d        = err_q;
		rem_d        = rem_q;
		burst_acc_d  = burst_acc_q;
		single_vld_d = 1'b0;
		single_acc_d = 1'b0;
		mem_we       = 1'b0;
		mem_re       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					single_vld_d = 1'b1;
					case (cmd_t'(cmd))
						CMD_WRITE: begin
							if (room) begin
								mem_we       = 1'b1;
								tail_d       = (tail_q == PW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
								fill_d       = fill_q + 1'b1;
								wr_total_d   = wr_total_q + 32'd1;
								single_acc_d = 1'b1;
							end
						end
						CMD_READ: begin
							if (over) begin
								err_d = 1'b1;
							end else if (cnt_c == 7'd0) begin
								single_acc_d = 1'b1;
							end else begin
								single_vld_d = 1'b0;
								head_d       = head_adv;
								fill_d       = fill_q - CW'(cnt_c);
								rd_ptr_d     = head_q;
								rem_d        = BW'(cnt_c);
								burst_acc_d  = 1'b1;
								state_d      = ST_BURST;
							end
						end
						CMD_PEEK: begin
							if (peek_n != '0) begin
								single_vld_d = 1'b0;
								rd_ptr_d     = head_q;
								rem_d        = peek_n;
								burst_acc_d  = 1'b0;
								state_d      = ST_BURST;
							end
						end
						CMD_POP: begin
							if (over) begin
								err_d = 1'b1;
							end else begin
								head_d       = head_adv;
								fill_d       = fill_q - CW'(cnt_c);
								single_acc_d = 1'b1;
							end
						end
						CMD_END: begin
							ended_d = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			ST_BURST: begin
				// issue one store read per cycle until the run is done
				mem_re   = 1'b1;
				rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
				rem_d    = rem_q - 1'b1;
				if (rem_q == BW'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control and status registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			rd_ptr_q     <= '0;
			fill_q       <= '0;
			wr_total_q   <= '0;
			ended_q      <= 1'b0;
			err_q        <= 1'b0;
			cap_q        <= CAP_RESET;
			rem_q        <= '0;
			burst_acc_q  <= 1'b0;
			single_vld_q <= 1'b0;
			single_acc_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
			rd_last_s1   <= 1'b0;
			rd_acc_s1    <= 1'b0;
		end else begin
			state_q      <= state_d;
			head_q       <= head_d;
			tail_q       <= tail_d;
			rd_ptr_q     <= rd_ptr_d;
			fill_q       <= fill_d;
			wr_total_q   <= wr_total_d;
			ended_q      <= ended_d;
			err_q        <= err_d;
			rem_q        <= rem_d;
			burst_acc_q  <= burst_acc_d;
			single_vld_q <= single_vld_d;
			single_acc_q <= single_acc_d;
			rd_vld_s1    <= mem_re;
			rd_last_s1   <= mem_re && (rem_q == BW'(1));
			rd_acc_s1    <= burst_acc_q;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
		end
	end

	bbfs_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(tail_q),
		.wdata(data_in),
		.re   (mem_re),
		.raddr(rd_ptr_q),
		.rdata(mem_rdata)
	);

	// result beat
	assign strobe        = single_vld_q || rd_vld_s1;
	assign data_out      = rd_vld_s1 ? mem_rdata : 8'd0;
	assign last          = single_vld_q || rd_last_s1;
	assign accepted      = single_vld_q ? single_acc_q : (rd_vld_s1 && rd_acc_s1);
	assign error_flag    = err_q;
	assign occupancy     = 11'(fill_q);
	assign space_left    = 11'(space);
	assign total_written = wr_total_q;
	assign total_read    = wr_total_q - 32'(fill_q);
	assign stream_ended  = ended_q;
	assign at_eof        = ended_q && (fill_q == '0);

endmodule

// ----- hdl/bbfs_mem.sv -----
// Byte store: one write port, one read port with registered read data.
module bbfs_mem import bbfs_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_s1;

	// store a byte
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// fetch a byte into the registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_s1 <= mem[raddr];
		end
	end

	assign rdata = rdata_s1;

endmodule

// ----- hdl/bbfs_chk.sv -----
// Port-level checker for the byte FIFO stream unit, bound to the top level.
`include "bounded_byte_fifo_stream_unit_macros.svh"

module bbfs_chk import bbfs_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [2:0]  cmd,
	input logic        strobe,
	input logic        last,
	input logic [7:0]  data_out,
	input logic        error_flag,
	input logic        stream_ended,
	input logic [31:0] total_written
);

	logic wr_take;

	// a byte write taken at this edge
	assign wr_take = start && !busy && (cmd == CMD_WRITE);

	// a byte write answers with one closing beat in the next cycle
	`BBFS_ASSERT_NXT(a_write_beat, clk, arst_n, wr_take, strobe && last && data_out == 8'd0)

	// the closing beat of a run never shows while the unit is still busy
	`BBFS_ASSERT_IMP(a_last_idle, clk, arst_n, strobe && last, !busy)

	// error and end of input stay set until reset
	`BBFS_ASSERT_NXT(a_err_sticky, clk, arst_n, error_flag, error_flag)
	`BBFS_ASSERT_NXT(a_end_sticky, clk, arst_n, stream_ended, stream_ended)

	// the written count moves by at most one byte per cycle
	`BBFS_ASSERT_NXT(a_wr_step, clk, arst_n, 1'b1, total_written - $past(total_written) <= 32'd1)

endmodule

bind bounded_byte_fifo_stream_unit bbfs_chk u_bbfs_chk (.*);
